### src/ilist_pkg.sv
package ilist_pkg;

  localparam int DEPTH  = 64;
  localparam int ELEM_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // request kinds
  localparam logic [2:0] REQ_INSERT = 3'd0;
  localparam logic [2:0] REQ_REMOVE = 3'd1;
  localparam logic [2:0] REQ_READ   = 3'd2;
  localparam logic [2:0] REQ_FIND   = 3'd3;
  localparam logic [2:0] REQ_PUSH   = 3'd4;
  localparam logic [2:0] REQ_POP    = 3'd5;

  // cell shift operations
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_INS  = 2'd1;
  localparam logic [1:0] OP_DEL  = 2'd2;

  typedef logic [DEPTH-1:0][ELEM_W-1:0] elem_vec_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [CNT_W-1:0]  pos;
    logic [ELEM_W-1:0] value;
    logic              look;
    logic              by_pos;
    logic [CNT_W-1:0]  count;
  } cell_ctl_t;

endpackage

### src/ilist_cell.sv
module ilist_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [ilist_pkg::IDX_W-1:0]  idx,
  input  ilist_pkg::cell_ctl_t       ctl,
  input  logic [ilist_pkg::ELEM_W-1:0] below,
  input  logic [ilist_pkg::ELEM_W-1:0] above,
  output logic [ilist_pkg::ELEM_W-1:0] elem,
  output logic                       hit
);
  import ilist_pkg::*;

  logic [CNT_W-1:0] my_idx;
  logic             hit_next;

  assign my_idx = CNT_W'(idx);

  // shift up on insert, down on remove, write the new value at the slot
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_INS: begin
        if (my_idx == ctl.pos) begin
          elem <= ctl.value;
        end else if (my_idx > ctl.pos) begin
          elem <= below;
        end
      end
      OP_DEL: begin
        if (my_idx >= ctl.pos) begin
          elem <= above;
        end
      end
      default: begin
      end
    endcase
  end

  assign hit_next = ctl.by_pos ? (my_idx == ctl.pos)
                               : ((my_idx < ctl.count) && (elem == ctl.value));

  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (ctl.look) begin
      hit <= hit_next;
    end
  end

endmodule

### src/ilist_reduce.sv
module ilist_reduce (
  input  logic [ilist_pkg::DEPTH-1:0]   hits,
  input  ilist_pkg::elem_vec_t        ents,
  output logic                        any,
  output logic [ilist_pkg::IDX_W-1:0]   index,
  output logic [ilist_pkg::ELEM_W-1:0]  data
);
  import ilist_pkg::*;

  logic [DEPTH-1:0] lowest;

  // isolate the lowest set hit bit
  assign lowest = hits & (~hits + DEPTH'(1));
  assign any    = |hits;

  always_comb begin
    index = '0;
    data  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (lowest[i]) begin
        index = index | IDX_W'(i);
        data  = data | ents[i];
      end
    end
  end

endmodule

### src/indexed_list_insert_remove_find_core.sv
// An accepted request moves the block to the reduce state; the response
// is registered at the end of that state and held until taken, and the
// request slot stays closed until then. On insert or remove the cell chain
// shifts entries at and above the position in the accept cycle; the reduce
// state picks the lowest hit. Reset (rst, synchronous) empties the list.
module indexed_list_insert_remove_find_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [2:0] req_type, [9:3] position, [41:10] elem_value, [47:42] zero
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [0] ok, [32:1] read_value, [38:33] match_index, [45:39] entry_count,
  // [47:46] zero
  output logic [47:0] m_tdata
);
  import ilist_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_HOLD   = 2'd2;

  logic [1:0]        state;
  logic [CNT_W-1:0]  occ;
  logic [CNT_W-1:0]  occ_next;

  logic [2:0]        req_type;
  logic [CNT_W-1:0]  position;
  logic [ELEM_W-1:0] elem_value;
  logic              accept;

  logic              ok_now;
  cell_ctl_t         ctl;

  // request latched for the reduce cycle
  logic [2:0]        kind_q;
  logic              ok_q;

  elem_vec_t         ents;
  logic [DEPTH-1:0]  hits;
  logic              any;
  logic [IDX_W-1:0]  index;
  logic [ELEM_W-1:0] data;

  logic              ok;
  logic [31:0]       read_value;
  logic [IDX_W-1:0]  match_index;

  assign req_type   = s_tdata[2:0];
  assign position   = s_tdata[9:3];
  assign elem_value = s_tdata[41:10];

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;

  // decode the request against the current fill level
  always_comb begin
    ok_now     = 1'b0;
    occ_next   = occ;
    ctl.op     = OP_NONE;
    ctl.pos    = position;
    ctl.value  = elem_value;
    ctl.look   = 1'b0;
    ctl.by_pos = 1'b0;
    ctl.count  = occ;
    case (req_type)
      REQ_INSERT: begin
        ok_now = (position <= occ) && (occ != CNT_W'(DEPTH));
        if (ok_now) begin
          ctl.op   = OP_INS;
          occ_next = occ + CNT_W'(1);
        end
      end
      REQ_REMOVE: begin
        ok_now = (position < occ);
        if (ok_now) begin
          ctl.op   = OP_DEL;
          occ_next = occ - CNT_W'(1);
        end
      end
      REQ_READ: begin
        ok_now     = (position < occ);
        ctl.look   = 1'b1;
        ctl.by_pos = 1'b1;
      end
      REQ_FIND: begin
        ctl.look = 1'b1;
      end
      REQ_PUSH: begin
        ok_now  = (occ != CNT_W'(DEPTH));
        ctl.pos = occ;
        if (ok_now) begin
          ctl.op   = OP_INS;
          occ_next = occ + CNT_W'(1);
        end
      end
      REQ_POP: begin
        ok_now  = (occ != '0);
        ctl.pos = occ - CNT_W'(1);
        if (ok_now) begin
          ctl.op   = OP_DEL;
          occ_next = occ - CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
    // drop any cell action unless the request is really taken
    if (!accept) begin
      ctl.op   = OP_NONE;
      ctl.look = 1'b0;
      occ_next = occ;
    end
  end

  // the cell chain: each inner cell sees its lower and upper neighbor
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ELEM_W-1:0] below;
    logic [ELEM_W-1:0] above;
    if (i == 0) begin : g_first
      assign below = ctl.value;
    end else begin : g_mid_lo
      assign below = ents[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign above = ents[i];
    end else begin : g_mid_hi
      assign above = ents[i+1];
    end
    ilist_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .idx   (IDX_W'(i)),
      .ctl   (ctl),
      .below (below),
      .above (above),
      .elem  (ents[i]),
      .hit   (hits[i])
    );
  end

  // lowest hit and its entry; contents are unchanged by read and find
  ilist_reduce u_reduce (
    .hits  (hits),
    .ents  (ents),
    .any   (any),
    .index (index),
    .data  (data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      occ      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      occ <= occ_next;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            state <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          m_tvalid <= 1'b1;
          state    <= ST_HOLD;
        end
        ST_HOLD: begin
          if (m_tready) begin
            m_tvalid <= 1'b0;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // hold the request kind and early status for the reduce cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_q <= req_type;
      ok_q   <= ok_now;
    end
  end

  // load the response register at the end of the reduce cycle
  always_ff @(posedge clk) begin
    if (state == ST_REDUCE) begin
      ok          <= (kind_q == REQ_FIND) ? any : ok_q;
      read_value  <= ((kind_q == REQ_READ) && ok_q) ? 32'(data) : 32'd0;
      match_index <= ((kind_q == REQ_FIND) && any) ? index : '0;
    end
  end

  assign m_tdata = {2'b00, occ, match_index, read_value, ok};

endmodule

### src/ilist_chk.sv
module ilist_chk (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata
);

  // one request at a time: the slot closes right after a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request taken while another is in flight");

  // every taken request is answered after the reduce state
  a_response_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |-> ##2 m_tvalid)
    else $error("response missing two cycles after request");

  // a stalled response holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled response changed");

  // a failed request never carries read data or a match index, and the count stays in range
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tdata[0]) |-> ((m_tdata[32:1] == 32'd0) && (m_tdata[38:33] == 6'd0)))
    else $error("failed request carries data");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[45:39] <= 7'd64))
    else $error("entry count beyond capacity");

endmodule

bind indexed_list_insert_remove_find_core ilist_chk u_ilist_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

### sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import ilist_pkg::*;

  // request kinds the block must ignore
  localparam logic [2:0] REQ_SPARE_LO = 3'd6;
  localparam logic [2:0] REQ_SPARE_HI = 3'd7;

  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_AT     = 500;
  localparam int RANDOM_REQS = 1330;

  typedef enum logic [1:0] {
    MODE_FREE, MODE_SEND_IDLE, MODE_RECV_STALL, MODE_BOTH
  } idle_mode_e;

  typedef struct {
    logic [2:0]        kind;
    logic [6:0]        pos;
    logic [ELEM_W-1:0] value;
    idle_mode_e        mode;
    logic              drain;
  } list_req_t;

  typedef struct {
    logic              ok;
    logic [31:0]       rd;
    logic [5:0]        idx;
    logic [6:0]        cnt;
    idle_mode_e        mode;
  } list_resp_t;

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;

  list_req_t  pending[$];
  list_resp_t resp_due[$];
  list_req_t  cur_req;

  // predicted list contents
  logic [ELEM_W-1:0] list_store [DEPTH];
  int                list_len = 0;

  int gen_len = 0;
  int errors = 0;
  int resps_seen = 0;
  int hold_left = 0;
  logic hold_used = 1'b0;
  int quiet = 0;
  logic [31:0] value_pool [8];

  indexed_list_insert_remove_find_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Apply one request to the predicted list and return its response.
  function automatic list_resp_t list_apply(list_req_t rq);
    list_resp_t r;
    int at;
    int k;
    r = '{ok: 1'b0, rd: '0, idx: '0, cnt: '0, mode: rq.mode};
    case (rq.kind)
      REQ_INSERT, REQ_PUSH: begin
        at = (rq.kind == REQ_PUSH) ? list_len : int'(rq.pos);
        if (at <= list_len && list_len < DEPTH) begin
          for (k = list_len; k > at; k--) list_store[k] = list_store[k-1];
          list_store[at] = rq.value;
          list_len++;
          r.ok = 1'b1;
        end
      end
      REQ_REMOVE, REQ_POP: begin
        at = (rq.kind == REQ_POP) ? list_len - 1 : int'(rq.pos);
        if (at >= 0 && at < list_len) begin
          list_len--;
          for (k = at; k < list_len; k++) list_store[k] = list_store[k+1];
          r.ok = 1'b1;
        end
      end
      REQ_READ: begin
        if (int'(rq.pos) < list_len) begin
          r.rd = list_store[rq.pos[5:0]];
          r.ok = 1'b1;
        end
      end
      REQ_FIND: begin
        for (k = 0; k < list_len; k++) begin
          if (list_store[k] == rq.value) begin
            r.idx = k[5:0];
            r.ok  = 1'b1;
            break;
          end
        end
      end
      default: ;
    endcase
    r.cnt = list_len[6:0];
    return r;
  endfunction

  // Queue a request and track the resulting length so the generator can
  // aim positions at live entries.
  task automatic add_req(logic [2:0] kind, logic [6:0] pos, logic [31:0] value,
                         idle_mode_e mode, logic drain);
    pending.push_back('{kind: kind, pos: pos, value: value, mode: mode, drain: drain});
    case (kind)
      REQ_INSERT: if (pos <= gen_len && gen_len < DEPTH) gen_len++;
      REQ_PUSH:   if (gen_len < DEPTH) gen_len++;
      REQ_REMOVE: if (pos < gen_len) gen_len--;
      REQ_POP:    if (gen_len > 0) gen_len--;
      default: ;
    endcase
  endtask

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 45) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  function automatic logic [6:0] pick_pos(int len);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 7'(len == 0 ? 0 : $urandom_range(0, len));
    if (r < 90) return 7'($urandom_range(0, 127));
    if (r < 95) return 7'(len);
    return 7'(DEPTH);
  endfunction

  // Driver: offer the next pending request, hold it until it is taken.
  always @(posedge clk) begin : drive
    logic busy;
    logic offer;
    list_req_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      busy = s_tvalid;
      if (s_tvalid && s_tready) begin
        resp_due.push_back(list_apply(cur_req));
        busy = 1'b0;
      end
      if (!busy) begin
        offer = pending.size() != 0;
        if (offer) begin
          nxt = pending[0];
          // hold a draining request back until the list has answered everything
          if (nxt.drain && resp_due.size() != 0) offer = 1'b0;
          if (nxt.mode == MODE_SEND_IDLE && $urandom_range(0, 99) < 47) offer = 1'b0;
          if (nxt.mode == MODE_BOTH && $urandom_range(0, 99) < 12) offer = 1'b0;
        end
        if (offer) begin
          void'(pending.pop_front());
          cur_req = nxt;
          s_tdata <= {6'b0, nxt.value, nxt.pos, nxt.kind};
        end
        s_tvalid <= offer;
      end
    end
  end

  // Monitor: check each response against the oldest prediction, then
  // decide whether to stall the next one.
  always @(posedge clk) begin : watch
    list_resp_t want;
    idle_mode_e mode;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        resps_seen <= resps_seen + 1;
        if (resp_due.size() == 0) begin
          flag_mismatch("unexpected response", m_tdata[31:0], '0);
        end else begin
          want = resp_due.pop_front();
          if (m_tdata[0] !== want.ok)
            flag_mismatch("ok", 32'(m_tdata[0]), 32'(want.ok));
          if (m_tdata[32:1] !== want.rd) flag_mismatch("read_value", m_tdata[32:1], want.rd);
          if (m_tdata[38:33] !== want.idx)
            flag_mismatch("match_index", 32'(m_tdata[38:33]), 32'(want.idx));
          if (m_tdata[45:39] !== want.cnt)
            flag_mismatch("entry_count", 32'(m_tdata[45:39]), 32'(want.cnt));
        end
      end
      mode = (resp_due.size() != 0) ? resp_due[0].mode : MODE_FREE;
      if (hold_left != 0)
        m_tready <= 1'b0;
      else if (mode == MODE_RECV_STALL)
        m_tready <= $urandom_range(0, 99) >= 47;
      else if (mode == MODE_BOTH)
        m_tready <= $urandom_range(0, 99) >= 12;
      else
        m_tready <= 1'b1;
    end
  end

  // Long receiver hold-off: lets the request side back up and stall.
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && resps_seen == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : stimulus
    int n;
    int seg;
    int bias;
    int r;
    logic [2:0] kind;
    idle_mode_e mode;

    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    for (int k = 2; k < 8; k++) value_pool[k] = $urandom;

    // empty list: every access fails
    add_req(REQ_POP,    7'd0,   32'h0, MODE_FREE, 1'b0);
    add_req(REQ_REMOVE, 7'd0,   32'h0, MODE_FREE, 1'b0);
    add_req(REQ_READ,   7'd0,   32'h0, MODE_FREE, 1'b0);
    add_req(REQ_FIND,   7'd0,   32'h0, MODE_FREE, 1'b0);
    add_req(REQ_INSERT, 7'd1,   32'h1, MODE_FREE, 1'b0);
    add_req(REQ_INSERT, 7'd127, 32'h2, MODE_FREE, 1'b0);
    // build a short list at front, middle and end
    add_req(REQ_INSERT, 7'd0,   32'hFFFF_FFFF, MODE_FREE, 1'b0);
    add_req(REQ_INSERT, 7'd0,   32'h0000_0000, MODE_FREE, 1'b0);
    add_req(REQ_INSERT, 7'd2,   32'hA5A5_A5A5, MODE_FREE, 1'b0);
    add_req(REQ_INSERT, 7'd1,   32'h5A5A_5A5A, MODE_FREE, 1'b0);
    add_req(REQ_PUSH,   7'd127, 32'h1234_5678, MODE_FREE, 1'b0);
    add_req(REQ_READ,   7'd0,   32'h0, MODE_FREE, 1'b0);
    add_req(REQ_READ,   7'd4,   32'h0, MODE_FREE, 1'b0);
    add_req(REQ_READ,   7'd5,   32'h0, MODE_FREE, 1'b0);
    add_req(REQ_READ,   7'd127, 32'h0, MODE_FREE, 1'b0);
    add_req(REQ_FIND,   7'd0,   32'hA5A5_A5A5, MODE_FREE, 1'b0);
    add_req(REQ_FIND,   7'd0,   32'h0000_0000, MODE_FREE, 1'b0);
    add_req(REQ_FIND,   7'd0,   32'hDEAD_BEEF, MODE_FREE, 1'b0);
    add_req(REQ_REMOVE, 7'd1,   32'h0, MODE_FREE, 1'b0);
    add_req(REQ_REMOVE, 7'd4,   32'h0, MODE_FREE, 1'b0);
    add_req(REQ_POP,    7'd0,   32'h0, MODE_FREE, 1'b0);
    add_req(REQ_SPARE_LO, 7'd127, 32'hFFFF_FFFF, MODE_FREE, 1'b0);
    add_req(REQ_SPARE_HI, 7'd0,   32'h0, MODE_FREE, 1'b0);
    add_req(REQ_REMOVE, 7'd0,   32'h0, MODE_FREE, 1'b0);

    // random part: segments that grow, shrink or churn the list; the first
    // one fills it to capacity and keeps pushing against the full list
    n = 0;
    bias = 0;
    while (n < RANDOM_REQS) begin
      seg = (n == 0) ? 75 : $urandom_range(40, 120);
      for (int j = 0; j < seg && n < RANDOM_REQS; j++) begin
        mode = idle_mode_e'((n / 150) % 4);
        r = $urandom_range(0, 99);
        if (n < 75)
          kind = (r < 50) ? REQ_INSERT : REQ_PUSH;
        else if (bias == 0)
          kind = r < 45 ? REQ_INSERT : r < 85 ? REQ_PUSH : r < 90 ? REQ_READ :
                 r < 96 ? REQ_FIND : r < 98 ? REQ_REMOVE : r < 99 ? REQ_POP :
                 REQ_SPARE_LO;
        else if (bias == 1)
          kind = r < 10 ? REQ_INSERT : r < 15 ? REQ_PUSH : r < 45 ? REQ_REMOVE :
                 r < 80 ? REQ_POP : r < 88 ? REQ_READ : r < 97 ? REQ_FIND :
                 REQ_SPARE_HI;
        else
          kind = r < 18 ? REQ_INSERT : r < 34 ? REQ_PUSH : r < 50 ? REQ_REMOVE :
                 r < 62 ? REQ_POP : r < 78 ? REQ_READ : r < 96 ? REQ_FIND :
                 r < 98 ? REQ_SPARE_LO : REQ_SPARE_HI;
        add_req(kind, pick_pos(gen_len), pick_value(), mode, n == 0 || n == 700);
        n++;
      end
      bias = $urandom_range(0, 2);
    end

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (pending.size() != 0 || s_tvalid || resp_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
